// File: rtl/scv_pkg.sv
`default_nettype none

package scv_pkg;

   // Fixed widths of the motion fields
   localparam int ACC_W     = 29;
   localparam int ACC_OUT_W = 30;
   localparam int VEL_W     = 44;
   localparam int POS_W     = 61;
   localparam int IDX_W     = 15;
   localparam int SEG_W     = 3;
   localparam int NUM_SEGS  = 7;

   localparam logic [SEG_W-1:0] SEG_DONE = 3'd7;
   localparam logic [IDX_W-1:0] TICK_MAX = 15'h7FFF;

   // Register indexes on the write port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_JERK_STEP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JERK_TICKS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_TICKS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSED     = 3'd4;

   // Profile state seen by the result stage
   typedef struct packed {
      logic [SEG_W-1:0]        segment;
      logic [IDX_W-1:0]        tick_count;
      logic signed [ACC_W-1:0] accel;
      logic signed [VEL_W-1:0] vel2;
      logic signed [POS_W-1:0] pos6;
   } scv_state_type;

   // First nonempty segment at or after start, SEG_DONE if none is left
   function automatic logic [SEG_W-1:0] first_nonempty(input logic [SEG_W-1:0] start,
                                                       input logic [NUM_SEGS-1:0] nz);
      logic [SEG_W-1:0] res;
      logic             found;
      res   = SEG_DONE;
      found = 1'b0;
      for (int i = 0; i < NUM_SEGS; i++) begin
         if (!found && (i >= int'(start)) && nz[i]) begin
            res   = SEG_W'(i);
            found = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/scv_core.sv
`default_nettype none

module scv_core #(
   parameter int SEG_TICK_BITS = 12,
   parameter int JERK_BITS     = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step_en,
   input  wire logic                     restart,
   input  wire logic [JERK_BITS-1:0]     jerk_step,
   input  wire logic [SEG_TICK_BITS-1:0] seg_len,
   input  wire logic [6:0]               seg_nz,
   output scv_pkg::scv_state_type        state,
   output logic [SEG_TICK_BITS-1:0]      ticks_in_seg
);
   import scv_pkg::*;

   scv_state_type            state_ff, state_in;
   logic [SEG_TICK_BITS-1:0] tis_ff, tis_in, tis_inc;
   logic [ACC_W-1:0]         jerk_a, jerk_z;
   logic [ACC_W-1:0]         a_a;
   logic [VEL_W-1:0]         a_v, j_v, v_v;
   logic [POS_W-1:0]         a_p, j_p, v_p, p_p;

   // Signed jerk of the current segment
   always_comb begin
      jerk_z = ACC_W'(jerk_step);
      case (state_ff.segment)
         3'd0, 3'd6: jerk_a = jerk_z;
         3'd2, 3'd4: jerk_a = ACC_W'(0) - jerk_z;
         default:    jerk_a = '0;
      endcase
   end

   // Sign extension of the accumulators to the wider sums
   assign a_a = state_ff.accel;
   assign a_v = {{(VEL_W-ACC_W){a_a[ACC_W-1]}}, a_a};
   assign j_v = {{(VEL_W-ACC_W){jerk_a[ACC_W-1]}}, jerk_a};
   assign v_v = state_ff.vel2;
   assign a_p = {{(POS_W-ACC_W){a_a[ACC_W-1]}}, a_a};
   assign j_p = {{(POS_W-ACC_W){jerk_a[ACC_W-1]}}, jerk_a};
   assign v_p = {{(POS_W-VEL_W){v_v[VEL_W-1]}}, v_v};
   assign p_p = state_ff.pos6;
   assign tis_inc = tis_ff + SEG_TICK_BITS'(1);

   // Next state: restart, one exact integration tick, or hold when finished
   always_comb begin
      state_in = state_ff;
      tis_in   = tis_ff;
      if (restart) begin
         state_in.accel      = '0;
         state_in.vel2       = '0;
         state_in.pos6       = '0;
         state_in.tick_count = '0;
         state_in.segment    = first_nonempty(3'd0, seg_nz);
         tis_in              = '0;
      end else if (state_ff.segment != SEG_DONE) begin
         state_in.accel = a_a + jerk_a;
         state_in.vel2  = v_v + (a_v << 1) + j_v;
         state_in.pos6  = p_p + v_p + (v_p << 1) + a_p + (a_p << 1) + j_p;
         if (state_ff.tick_count != TICK_MAX) begin
            state_in.tick_count = state_ff.tick_count + IDX_W'(1);
         end
         tis_in = tis_inc;
         if ((tis_inc >= seg_len) || (tis_inc == '0)) begin
            state_in.segment = first_nonempty(state_ff.segment + SEG_W'(1), seg_nz);
            tis_in           = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.segment    <= SEG_DONE;
         state_ff.tick_count <= '0;
         state_ff.accel      <= '0;
         state_ff.vel2       <= '0;
         state_ff.pos6       <= '0;
         tis_ff              <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         tis_ff   <= tis_in;
      end
   end

   assign state        = state_ff;
   assign ticks_in_seg = tis_ff;

endmodule

`default_nettype wire

// File: rtl/scv_emit.sv
`default_nettype none

module scv_emit #(
   parameter int SEG_TICK_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                load,
   input  wire logic                                rsp_stall,
   input  wire scv_pkg::scv_state_type              state,
   input  wire logic [SEG_TICK_BITS-1:0]            ticks_in_seg,
   input  wire logic [SEG_TICK_BITS-1:0]            seg_len,
   input  wire logic [6:0]                          seg_nz,
   input  wire logic                                reversed,
   output logic                                     rsp_valid,
   output logic signed [scv_pkg::ACC_OUT_W-1:0]     rsp_accel_out,
   output logic signed [scv_pkg::VEL_W-1:0]         rsp_velocity_x2,
   output logic signed [scv_pkg::POS_W-1:0]         rsp_position_x6,
   output logic [scv_pkg::IDX_W-1:0]                rsp_sample_index,
   output logic [scv_pkg::SEG_W-1:0]                rsp_segment,
   output logic                                     rsp_last
);
   import scv_pkg::*;

   logic                  valid_ff, valid_in;
   logic [ACC_OUT_W-1:0]  acc_ff, acc_in, acc_ext;
   logic [VEL_W-1:0]      vel_ff, vel_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [IDX_W-1:0]      idx_ff;
   logic [SEG_W-1:0]      seg_ff, seg_in;
   logic                  last_ff, last_in;
   logic                  fin;
   logic [SEG_TICK_BITS:0] tis_next;

   assign fin      = (state.segment == SEG_DONE);
   assign acc_ext  = {state.accel[ACC_W-1], state.accel};
   assign tis_next = {1'b0, ticks_in_seg} + (SEG_TICK_BITS+1)'(1);

   // Result fields: zero when finished, negated in reverse mode
   always_comb begin
      if (fin) begin
         acc_in = '0;
         vel_in = '0;
         pos_in = '0;
      end else if (reversed) begin
         acc_in = ACC_OUT_W'(0) - acc_ext;
         vel_in = VEL_W'(0) - state.vel2;
         pos_in = POS_W'(0) - state.pos6;
      end else begin
         acc_in = acc_ext;
         vel_in = state.vel2;
         pos_in = state.pos6;
      end
      seg_in  = state.segment;
      last_in = !fin && (tis_next >= {1'b0, seg_len}) &&
                (first_nonempty(state.segment + SEG_W'(1), seg_nz) == SEG_DONE);
   end

   // Output register holds while the receiver stalls
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         acc_ff  <= acc_in;
         vel_ff  <= vel_in;
         pos_ff  <= pos_in;
         idx_ff  <= state.tick_count;
         seg_ff  <= seg_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_accel_out    = acc_ff;
   assign rsp_velocity_x2  = vel_ff;
   assign rsp_position_x6  = pos_ff;
   assign rsp_sample_index = idx_ff;
   assign rsp_segment      = seg_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

// File: rtl/scurve_trajectory_generator.sv
// S-curve trajectory generator, one profile tick per input item.
// Input channel (req_): req_restart=1 restarts the profile at tick zero,
// req_restart=0 advances one tick. Each accepted item gives exactly one
// result item on the rsp_ channel: acceleration, twice the velocity, six
// times the position, the tick number, the segment (7 when finished) and
// a flag on the final sample. The user writes the registers on the csr_
// port only while the block is idle; the block does not enforce this.
// Lengths of zero skip segments. An item updates the profile state at its
// accepting edge, and its result is registered once the output is free.
// Throughput: one item per cycle while the receiver does not stall; the
// tick update is three accumulator adds and a segment counter compare
// ahead of the state register. When the receiver stalls, the result
// register holds and one more item may be accepted into the profile state;
// after that req_stall follows rsp_stall until the result is taken.
// Reset (synchronous) leaves the profile finished (segment 7, all zero),
// the registers at their defaults and the output channel empty.
`default_nettype none

module scurve_trajectory_generator #(
   parameter int SEG_TICK_BITS = 12,
   parameter int JERK_BITS     = 16,
   localparam int CSR_W = (JERK_BITS > SEG_TICK_BITS) ? JERK_BITS : SEG_TICK_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_restart,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [scv_pkg::ACC_OUT_W-1:0]     rsp_accel_out,
   output logic signed [scv_pkg::VEL_W-1:0]         rsp_velocity_x2,
   output logic signed [scv_pkg::POS_W-1:0]         rsp_position_x6,
   output logic [scv_pkg::IDX_W-1:0]                rsp_sample_index,
   output logic [scv_pkg::SEG_W-1:0]                rsp_segment,
   output logic                                     rsp_last,
   input  wire logic                                csr_write_en,
   input  wire logic [scv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_W-1:0]                    csr_wdata
);
   import scv_pkg::*;

   logic [JERK_BITS-1:0]     jerk_step_ff;
   logic [SEG_TICK_BITS-1:0] jerk_ticks_ff, accel_ticks_ff, cruise_ticks_ff;
   logic                     reversed_ff;
   logic                     pend_ff, pend_in;
   logic                     accept, take, out_free;
   logic [SEG_TICK_BITS-1:0] seg_len;
   logic [6:0]               seg_nz;
   scv_state_type            state;
   logic [SEG_TICK_BITS-1:0] ticks_in_seg;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         jerk_step_ff    <= JERK_BITS'(1);
         jerk_ticks_ff   <= SEG_TICK_BITS'(1);
         accel_ticks_ff  <= '0;
         cruise_ticks_ff <= '0;
         reversed_ff     <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_JERK_STEP:    jerk_step_ff    <= csr_wdata[JERK_BITS-1:0];
            CSR_JERK_TICKS:   jerk_ticks_ff   <= csr_wdata[SEG_TICK_BITS-1:0];
            CSR_ACCEL_TICKS:  accel_ticks_ff  <= csr_wdata[SEG_TICK_BITS-1:0];
            CSR_CRUISE_TICKS: cruise_ticks_ff <= csr_wdata[SEG_TICK_BITS-1:0];
            CSR_REVERSED:     reversed_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Which segments are nonempty, and the length of the current one
   assign seg_nz = {jerk_ticks_ff != '0, accel_ticks_ff != '0, jerk_ticks_ff != '0,
                    cruise_ticks_ff != '0, jerk_ticks_ff != '0, accel_ticks_ff != '0,
                    jerk_ticks_ff != '0};

   always_comb begin
      case (state.segment)
         3'd0, 3'd2, 3'd4, 3'd6: seg_len = jerk_ticks_ff;
         3'd1, 3'd5:             seg_len = accel_ticks_ff;
         3'd3:                   seg_len = cruise_ticks_ff;
         default:                seg_len = '0;
      endcase
   end

   // Flow control: the state holds one item whose result is not yet registered
   assign out_free  = !rsp_valid || !rsp_stall;
   assign take      = pend_ff && out_free;
   assign req_stall = pend_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign pend_in   = accept || (pend_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   scv_core #(
      .SEG_TICK_BITS(SEG_TICK_BITS),
      .JERK_BITS    (JERK_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (accept),
      .restart     (req_restart),
      .jerk_step   (jerk_step_ff),
      .seg_len     (seg_len),
      .seg_nz      (seg_nz),
      .state       (state),
      .ticks_in_seg(ticks_in_seg)
   );

   scv_emit #(
      .SEG_TICK_BITS(SEG_TICK_BITS)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (take),
      .rsp_stall       (rsp_stall),
      .state           (state),
      .ticks_in_seg    (ticks_in_seg),
      .seg_len         (seg_len),
      .seg_nz          (seg_nz),
      .reversed        (reversed_ff),
      .rsp_valid       (rsp_valid),
      .rsp_accel_out   (rsp_accel_out),
      .rsp_velocity_x2 (rsp_velocity_x2),
      .rsp_position_x6 (rsp_position_x6),
      .rsp_sample_index(rsp_sample_index),
      .rsp_segment     (rsp_segment),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/scv_checker.sv
`default_nettype none

module scv_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [scv_pkg::ACC_OUT_W-1:0] rsp_accel_out,
   input wire logic signed [scv_pkg::VEL_W-1:0]     rsp_velocity_x2,
   input wire logic signed [scv_pkg::POS_W-1:0]     rsp_position_x6,
   input wire logic [scv_pkg::SEG_W-1:0]            rsp_segment,
   input wire logic                                rsp_last
);
   import scv_pkg::*;

   // A finished profile reports all zero motion and no final flag
   a_fin_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_segment == SEG_DONE) |->
      (rsp_accel_out == '0 && rsp_velocity_x2 == '0 && rsp_position_x6 == '0 && !rsp_last))
      else $error("finished result carries motion");

   // Input side only backs up behind a stalled, full output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with output free");

   // An accepted item always leads to a result waiting on the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ##1 rsp_valid)
      else $error("result missing two cycles after accept");

   // Stalled result stays valid; its position, segment and last flag stay unchanged
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped under stall");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      ($stable(rsp_position_x6) && $stable(rsp_segment) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind scurve_trajectory_generator scv_checker u_scv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_accel_out  (rsp_accel_out),
   .rsp_velocity_x2(rsp_velocity_x2),
   .rsp_position_x6(rsp_position_x6),
   .rsp_segment    (rsp_segment),
   .rsp_last       (rsp_last)
);

`default_nettype wire

// File: dv/scv_profile_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the
// S-curve profile state and checks every result item against it.
module scv_profile_checker #(
   parameter int SEG_TICK_BITS = 12,
   parameter int JERK_BITS     = 16,
   parameter int CSR_W         = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   input  wire logic                                   req_stall,
   input  wire logic                                   req_restart,
   input  wire logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   input  wire logic signed [scv_pkg::ACC_OUT_W-1:0]   rsp_accel_out,
   input  wire logic signed [scv_pkg::VEL_W-1:0]       rsp_velocity_x2,
   input  wire logic signed [scv_pkg::POS_W-1:0]       rsp_position_x6,
   input  wire logic [scv_pkg::IDX_W-1:0]              rsp_sample_index,
   input  wire logic [scv_pkg::SEG_W-1:0]              rsp_segment,
   input  wire logic                                   rsp_last,
   input  wire logic                                   csr_write_en,
   input  wire logic [scv_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_W-1:0]                       csr_wdata,
   output int                                          mismatches,
   output int                                          outstanding
);
   import scv_pkg::*;

   typedef struct {
      logic signed [ACC_OUT_W-1:0] accel;
      logic signed [VEL_W-1:0]     vel2;
      logic signed [POS_W-1:0]     pos6;
      logic [IDX_W-1:0]            index;
      logic [SEG_W-1:0]            segment;
      logic                        last;
   } motion_sample_type;

   motion_sample_type expected_samples[$];

   // Register copies
   logic [JERK_BITS-1:0]     cfg_jerk_step;
   logic [SEG_TICK_BITS-1:0] cfg_jerk_ticks;
   logic [SEG_TICK_BITS-1:0] cfg_accel_ticks;
   logic [SEG_TICK_BITS-1:0] cfg_cruise_ticks;
   logic                     cfg_reversed;

   // Profile state
   int                       prof_seg;
   logic [SEG_TICK_BITS-1:0] seg_ticks;
   logic [IDX_W-1:0]         tick_no;
   logic signed [ACC_W-1:0]  accel;
   logic signed [VEL_W-1:0]  vel2;
   logic signed [POS_W-1:0]  pos6;

   function automatic logic [SEG_TICK_BITS-1:0] span_of(input int s);
      case (s)
         0, 2, 4, 6: return cfg_jerk_ticks;
         1, 5:       return cfg_accel_ticks;
         3:          return cfg_cruise_ticks;
         default:    return '0;
      endcase
   endfunction

   // Jerk sign follows the S shape: up, down, down, up
   function automatic longint jerk_of(input int s);
      case (s)
         0, 6:    return longint'(cfg_jerk_step);
         2, 4:    return -longint'(cfg_jerk_step);
         default: return 0;
      endcase
   endfunction

   // Zero-length segments are skipped
   function automatic int next_live_segment(input int s);
      int k;
      k = s;
      while (k < int'(SEG_DONE) && span_of(k) == 0)
         k++;
      return k;
   endfunction

   // One tick of exact integer integration, or a restart
   task automatic advance_profile(input logic restart);
      longint j, a, v, p;
      if (restart) begin
         accel     = '0;
         vel2      = '0;
         pos6      = '0;
         tick_no   = '0;
         seg_ticks = '0;
         prof_seg  = next_live_segment(0);
      end else if (prof_seg < int'(SEG_DONE)) begin
         j = jerk_of(prof_seg);
         a = accel;
         v = vel2;
         p = pos6;
         accel = ACC_W'(a + j);
         vel2  = VEL_W'(v + 2 * a + j);
         pos6  = POS_W'(p + 3 * v + 3 * a + j);
         if (tick_no != TICK_MAX)
            tick_no++;
         seg_ticks = seg_ticks + 1'b1;
         // lengths are live: a shrunk segment ends at once
         if (seg_ticks >= span_of(prof_seg) || seg_ticks == 0) begin
            prof_seg  = next_live_segment(prof_seg + 1);
            seg_ticks = '0;
         end
      end
   endtask

   function automatic motion_sample_type current_sample();
      motion_sample_type s;
      logic              done;
      longint            a, v, p;
      done = prof_seg >= int'(SEG_DONE);
      a = 0;
      v = 0;
      p = 0;
      if (!done) begin
         a = accel;
         v = vel2;
         p = pos6;
      end
      if (cfg_reversed) begin
         a = -a;
         v = -v;
         p = -p;
      end
      s.accel   = ACC_OUT_W'(a);
      s.vel2    = VEL_W'(v);
      s.pos6    = POS_W'(p);
      s.index   = tick_no;
      s.segment = done ? SEG_DONE : SEG_W'(prof_seg);
      s.last    = !done && (int'(seg_ticks) + 1 >= int'(span_of(prof_seg))) &&
                  (next_live_segment(prof_seg + 1) == int'(SEG_DONE));
      return s;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] seen);
      if (want !== seen) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      motion_sample_type want;
      if (reset) begin
         cfg_jerk_step    = JERK_BITS'(1);
         cfg_jerk_ticks   = SEG_TICK_BITS'(1);
         cfg_accel_ticks  = '0;
         cfg_cruise_ticks = '0;
         cfg_reversed     = 1'b0;
         prof_seg         = int'(SEG_DONE);
         seg_ticks        = '0;
         tick_no          = '0;
         accel            = '0;
         vel2             = '0;
         pos6             = '0;
         expected_samples.delete();
      end else begin
         // results first, so a result can never match an item of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $error("result item with no item pending");
               mismatches++;
            end else begin
               want = expected_samples.pop_front();
               check_field("accel_out", want.accel, rsp_accel_out);
               check_field("velocity_x2", want.vel2, rsp_velocity_x2);
               check_field("position_x6", want.pos6, rsp_position_x6);
               check_field("sample_index", want.index, rsp_sample_index);
               check_field("segment", want.segment, rsp_segment);
               check_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && !req_stall) begin
            advance_profile(req_restart);
            expected_samples.insert(expected_samples.size(), current_sample());
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_JERK_STEP:    cfg_jerk_step    = csr_wdata[JERK_BITS-1:0];
               CSR_JERK_TICKS:   cfg_jerk_ticks   = csr_wdata[SEG_TICK_BITS-1:0];
               CSR_ACCEL_TICKS:  cfg_accel_ticks  = csr_wdata[SEG_TICK_BITS-1:0];
               CSR_CRUISE_TICKS: cfg_cruise_ticks = csr_wdata[SEG_TICK_BITS-1:0];
               CSR_REVERSED:     cfg_reversed     = csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding = expected_samples.size();
   end

endmodule

// File: dv/tb_scurve_trajectory_generator.sv
`timescale 1ns / 100ps

module tb_scurve_trajectory_generator;
   import scv_pkg::*;

   localparam int SEG_TICK_BITS = 12;
   localparam int JERK_BITS     = 16;
   localparam int CSR_W         = 16;
   localparam int RANDOM_ITEMS  = 1050;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 60;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_restart  = 1'b0;
   logic                   rsp_stall    = 1'b0;
   logic                   csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index    = CSR_JERK_STEP;
   logic [CSR_W-1:0]       csr_wdata    = '0;

   logic                        req_stall;
   logic                        rsp_valid;
   logic signed [ACC_OUT_W-1:0] rsp_accel_out;
   logic signed [VEL_W-1:0]     rsp_velocity_x2;
   logic signed [POS_W-1:0]     rsp_position_x6;
   logic [IDX_W-1:0]            rsp_sample_index;
   logic [SEG_W-1:0]            rsp_segment;
   logic                        rsp_last;

   int   mismatches;
   int   outstanding;
   int   items_sent    = 0;
   logic calm          = 1'b0;
   logic pressure_go   = 1'b0;
   logic pressure_done = 1'b0;
   int   hold_left     = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   scurve_trajectory_generator #(
      .SEG_TICK_BITS(SEG_TICK_BITS),
      .JERK_BITS    (JERK_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accel_out   (rsp_accel_out),
      .rsp_velocity_x2 (rsp_velocity_x2),
      .rsp_position_x6 (rsp_position_x6),
      .rsp_sample_index(rsp_sample_index),
      .rsp_segment     (rsp_segment),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   scv_profile_checker #(
      .SEG_TICK_BITS(SEG_TICK_BITS),
      .JERK_BITS    (JERK_BITS),
      .CSR_W        (CSR_W)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accel_out   (rsp_accel_out),
      .rsp_velocity_x2 (rsp_velocity_x2),
      .rsp_position_x6 (rsp_position_x6),
      .rsp_sample_index(rsp_sample_index),
      .rsp_segment     (rsp_segment),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   // Receiver: random stalls, one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (pressure_go && !pressure_done) begin
         rsp_stall     <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         pressure_done <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 9);
      end
   end

   // Watchdog
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("scurve_trajectory_generator verification failed");
      $finish;
   end

   // One tick item; acceptance is judged at the falling edge before the accept
   task automatic send_tick(input logic restart);
      while (!calm && $urandom_range(99) < 9) begin
         req_valid   <= 1'b0;
         req_restart <= 1'($urandom);
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic run_ticks(input int n);
      repeat (n) send_tick(1'b0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   // Unused upper data bits carry random junk
   task automatic load_profile(input logic [JERK_BITS-1:0] jstep,
                               input logic [SEG_TICK_BITS-1:0] jt,
                               input logic [SEG_TICK_BITS-1:0] at,
                               input logic [SEG_TICK_BITS-1:0] ct,
                               input logic rev);
      write_reg(CSR_JERK_STEP, jstep);
      write_reg(CSR_JERK_TICKS, {4'($urandom), jt});
      write_reg(CSR_ACCEL_TICKS, {4'($urandom), at});
      write_reg(CSR_CRUISE_TICKS, {4'($urandom), ct});
      write_reg(CSR_REVERSED, {15'($urandom), rev});
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Drain every pending result, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [JERK_BITS-1:0] jstep;
      int                   jt, at, ct, plen, extra, nseq, random_start;
      logic                 rev;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // never started, then the default one-tick jerk profile and past its end
      run_ticks(2);
      send_tick(1'b1);
      run_ticks(5);

      // all registers at their maximum, reversed
      settle();
      load_profile(16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
      send_tick(1'b1);
      run_ticks(3);

      // every length zero: restart lands straight on finished
      settle();
      load_profile('0, '0, '0, '0, 1'b0);
      send_tick(1'b1);
      send_tick(1'b0);

      // shrink the accel segment below the ticks already spent in it
      settle();
      load_profile(16'd7, 12'd3, 12'd5, 12'd2, 1'b0);
      send_tick(1'b1);
      run_ticks(5);
      settle();
      load_profile(16'd7, 12'd3, 12'd1, 12'd2, 1'b0);
      run_ticks(2);

      // receiver holds off for a long stretch while items keep coming
      settle();
      load_profile(16'd3, 12'd20, 12'd20, 12'd20, 1'b0);
      pressure_go <= 1'b1;
      send_tick(1'b1);
      run_ticks(100);

      // random profiles, mostly well formed with occasional stray restarts
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         settle();
         calm <= (items_sent - random_start >= 400) && (items_sent - random_start < 650);
         case ($urandom_range(9))
            0:       jstep = '1;
            1:       jstep = JERK_BITS'(1);
            2:       jstep = '0;
            default: jstep = JERK_BITS'($urandom);
         endcase
         if ($urandom_range(19) == 0) begin
            jt = $urandom_range(4095);
            at = $urandom_range(4095);
            ct = $urandom_range(4095);
         end else begin
            jt = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 5);
            at = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            ct = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
         end
         rev = 1'($urandom);
         load_profile(jstep, SEG_TICK_BITS'(jt), SEG_TICK_BITS'(at), SEG_TICK_BITS'(ct), rev);
         plen  = 4 * jt + 2 * at + ct;
         extra = $urandom_range(3);
         nseq  = (plen + extra > 60) ? 60 : plen + extra;
         // leaving out the restart runs on with the old profile under new lengths
         if ($urandom_range(99) < 85)
            send_tick(1'b1);
         repeat (nseq) send_tick($urandom_range(99) < 4);
      end

      settle();
      repeat (2) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("scurve_trajectory_generator verification clean");
      else
         $display("scurve_trajectory_generator verification failed");
      $finish;
   end

endmodule
